### hdl/lhc_pkg.sv
// lhc_pkg: shared types, constants and the rounding function of the
// lowpass / high-shelf cascade. No dependencies.
`timescale 1ns / 1ps
package lhc_pkg;

	// geometry
	localparam int LHC_CHANNELS  = 2;
	localparam int SAMPLE_W      = 24;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 24;
	localparam int FRAC_BITS     = 21;
	localparam int COEF_W        = 25;
	localparam int PROD_W        = 49;
	localparam int ACC_W         = 52;

	// register reset values
	localparam logic [20:0] RST_LOWPASS_POLE = 21'd1343900;
	localparam logic [21:0] RST_LOWPASS_GAIN = 22'd753252;
	localparam logic [23:0] RST_SHELF_B0     = 24'sd2191330;
	localparam logic [23:0] RST_SHELF_B1     = -24'sd2331020;
	localparam logic [23:0] RST_SHELF_B2     = 24'sd727480;
	localparam logic [23:0] RST_SHELF_A1     = -24'sd2184190;
	localparam logic [23:0] RST_SHELF_A2     = 24'sd674820;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOWPASS_POLE = 3'd0,
		REG_LOWPASS_GAIN = 3'd1,
		REG_SHELF_B0     = 3'd2,
		REG_SHELF_B1     = 3'd3,
		REG_SHELF_B2     = 3'd4,
		REG_SHELF_A1     = 3'd5,
		REG_SHELF_A2     = 3'd6
	} reg_idx_t;

	// coefficient bank
	typedef struct packed {
		logic [20:0] lowpass_pole;
		logic [21:0] lowpass_gain;
		logic [23:0] shelf_b0;
		logic [23:0] shelf_b1;
		logic [23:0] shelf_b2;
		logic [23:0] shelf_a1;
		logic [23:0] shelf_a2;
	} coef_t;

	// multiplier operand pair
	typedef enum logic [2:0] {
		SEL_GAIN_X  = 3'd0,
		SEL_POLE_LP = 3'd1,
		SEL_B0_LP   = 3'd2,
		SEL_B1_X1   = 3'd3,
		SEL_B2_X2   = 3'd4,
		SEL_A1_Y1   = 3'd5,
		SEL_A2_Y2   = 3'd6
	} mul_sel_t;

	// accumulator operation
	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2,
		ACC_SUB  = 2'd3
	} acc_op_t;

	// controller to datapath
	typedef struct packed {
		logic     capture;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     lp_save;
		logic     finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pass_in;
	} status_t;

	// round half up, drop the fraction, saturate to 24 bits
	function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0]           v;
		logic signed [ACC_W-FRAC_BITS-1:0] q;
		v = acc + ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
		q = v[ACC_W-1:FRAC_BITS];
		if (q > (ACC_W-FRAC_BITS)'(8388607))
			return 24'h7fffff;
		else if (q < -(ACC_W-FRAC_BITS)'(8388608))
			return 24'h800000;
		else
			return q[SAMPLE_W-1:0];
	endfunction

endpackage

### hdl/lhc_in_if.sv
// lhc_in_if: input channel of the cascade, valid/ready with sample payload.
// No dependencies.
`timescale 1ns / 1ps
interface lhc_in_if;
	logic        valid;
	logic        ready;
	logic [23:0] sample_in;
	logic        channel;
	logic        enable;

	modport source (output valid, sample_in, channel, enable, input ready);
	modport sink   (input valid, sample_in, channel, enable, output ready);
endinterface

### hdl/lhc_out_if.sv
// lhc_out_if: output channel of the cascade, valid/ready with sample payload.
// No dependencies.
`timescale 1ns / 1ps
interface lhc_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] sample_out;
	logic        channel_out;

	modport source (output valid, sample_out, channel_out, input ready);
	modport sink   (input valid, sample_out, channel_out, output ready);
endinterface

### hdl/lhc_regs.sv
// lhc_regs: coefficient register bank written through the config port.
// Depends on lhc_pkg.
`timescale 1ns / 1ps
module lhc_regs
	import lhc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output coef_t                 coef
);

	coef_t coef_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.lowpass_pole <= RST_LOWPASS_POLE;
			coef_q.lowpass_gain <= RST_LOWPASS_GAIN;
			coef_q.shelf_b0     <= RST_SHELF_B0;
			coef_q.shelf_b1     <= RST_SHELF_B1;
			coef_q.shelf_b2     <= RST_SHELF_B2;
			coef_q.shelf_a1     <= RST_SHELF_A1;
			coef_q.shelf_a2     <= RST_SHELF_A2;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_LOWPASS_POLE: coef_q.lowpass_pole <= cfg_data[20:0];
				REG_LOWPASS_GAIN: coef_q.lowpass_gain <= cfg_data[21:0];
				REG_SHELF_B0:     coef_q.shelf_b0     <= cfg_data;
				REG_SHELF_B1:     coef_q.shelf_b1     <= cfg_data;
				REG_SHELF_B2:     coef_q.shelf_b2     <= cfg_data;
				REG_SHELF_A1:     coef_q.shelf_a1     <= cfg_data;
				REG_SHELF_A2:     coef_q.shelf_a2     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

### hdl/lhc_ctrl.sv
// lhc_ctrl: sequencer for the shared multiply-accumulate and the output
// valid flag. Depends on lhc_pkg.
`timescale 1ns / 1ps
module lhc_ctrl
	import lhc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_MAC0 = 10'b00_0000_0010,
		ST_MAC1 = 10'b00_0000_0100,
		ST_MAC2 = 10'b00_0000_1000,
		ST_MAC3 = 10'b00_0001_0000,
		ST_MAC4 = 10'b00_0010_0000,
		ST_MAC5 = 10'b00_0100_0000,
		ST_MAC6 = 10'b00_1000_0000,
		ST_MAC7 = 10'b01_0000_0000,
		ST_FIN  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// next state and datapath commands
	always_comb begin
		state_nxt   = state_q;
		cmd.capture = accept;
		cmd.mul_sel = SEL_GAIN_X;
		cmd.acc_op  = ACC_HOLD;
		cmd.lp_save = 1'b0;
		cmd.finish  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_nxt = status.pass_in ? ST_FIN : ST_MAC0;
			end
			ST_MAC0: begin
				cmd.mul_sel = SEL_GAIN_X;
				state_nxt   = ST_MAC1;
			end
			ST_MAC1: begin
				cmd.mul_sel = SEL_POLE_LP;
				cmd.acc_op  = ACC_LOAD;
				state_nxt   = ST_MAC2;
			end
			ST_MAC2: begin
				cmd.mul_sel = SEL_B1_X1;
				cmd.acc_op  = ACC_ADD;
				state_nxt   = ST_MAC3;
			end
			ST_MAC3: begin
				cmd.mul_sel = SEL_B2_X2;
				cmd.acc_op  = ACC_LOAD;
				cmd.lp_save = 1'b1;
				state_nxt   = ST_MAC4;
			end
			ST_MAC4: begin
				cmd.mul_sel = SEL_B0_LP;
				cmd.acc_op  = ACC_ADD;
				state_nxt   = ST_MAC5;
			end
			ST_MAC5: begin
				cmd.mul_sel = SEL_A1_Y1;
				cmd.acc_op  = ACC_ADD;
				state_nxt   = ST_MAC6;
			end
			ST_MAC6: begin
				cmd.mul_sel = SEL_A2_Y2;
				cmd.acc_op  = ACC_SUB;
				state_nxt   = ST_MAC7;
			end
			ST_MAC7: begin
				cmd.acc_op = ACC_SUB;
				state_nxt  = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.finish)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;

endmodule

### hdl/lhc_dpath.sv
// lhc_dpath: input capture, per-channel filter state, shared multiplier,
// accumulator and output payload register. Depends on lhc_pkg.
`timescale 1ns / 1ps
module lhc_dpath
	import lhc_pkg::*;
#(
	parameter int CHANNELS = LHC_CHANNELS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SAMPLE_W-1:0] sample_in,
	input  logic                channel,
	input  logic                enable,
	input  coef_t               coef,
	input  cmd_t                cmd,
	output status_t             status,
	output logic [SAMPLE_W-1:0] sample_out,
	output logic                channel_out
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic signed [SAMPLE_W-1:0] x_q;
	logic                       chan_q;
	logic                       pass_q;
	logic [CH_W-1:0]            idx;

	logic signed [SAMPLE_W-1:0] lp_mem_q  [CHANNELS];
	logic signed [SAMPLE_W-1:0] x1_q      [CHANNELS];
	logic signed [SAMPLE_W-1:0] x2_q      [CHANNELS];
	logic signed [SAMPLE_W-1:0] y1_q      [CHANNELS];
	logic signed [SAMPLE_W-1:0] y2_q      [CHANNELS];

	logic signed [SAMPLE_W-1:0] lp_q;
	logic signed [COEF_W-1:0]   op_a;
	logic signed [SAMPLE_W-1:0] op_b;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [ACC_W-1:0]    prod_ext;
	logic signed [ACC_W-1:0]    acc_q;
	logic        [SAMPLE_W-1:0] result;
	logic [SAMPLE_W-1:0]        sample_q;
	logic                       chan_out_q;

	// channels past the state depth and disabled items pass through
	assign status.pass_in = !enable || (32'(channel) >= CHANNELS);
	assign idx            = CH_W'(chan_q);

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q    <= sample_in;
			chan_q <= channel;
			pass_q <= status.pass_in;
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		case (cmd.mul_sel)
			SEL_GAIN_X: begin
				op_a = {3'b000, coef.lowpass_gain};
				op_b = x_q;
			end
			SEL_POLE_LP: begin
				op_a = {4'b0000, coef.lowpass_pole};
				op_b = lp_mem_q[idx];
			end
			SEL_B0_LP: begin
				op_a = {coef.shelf_b0[23], coef.shelf_b0};
				op_b = lp_q;
			end
			SEL_B1_X1: begin
				op_a = {coef.shelf_b1[23], coef.shelf_b1};
				op_b = x1_q[idx];
			end
			SEL_B2_X2: begin
				op_a = {coef.shelf_b2[23], coef.shelf_b2};
				op_b = x2_q[idx];
			end
			SEL_A1_Y1: begin
				op_a = {coef.shelf_a1[23], coef.shelf_a1};
				op_b = y1_q[idx];
			end
			SEL_A2_Y2: begin
				op_a = {coef.shelf_a2[23], coef.shelf_a2};
				op_b = y2_q[idx];
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// product register
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	assign prod_ext = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};

	// accumulator
	always_ff @(posedge clk) begin
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= prod_ext;
			ACC_ADD:  acc_q <= acc_q + prod_ext;
			ACC_SUB:  acc_q <= acc_q - prod_ext;
			default:  acc_q <= acc_q;
		endcase
	end

	// lowpass output, rounded from the first sum
	always_ff @(posedge clk) begin
		if (cmd.lp_save)
			lp_q <= round_sat(acc_q);
	end

	assign result = round_sat(acc_q);

	// per-channel filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				lp_mem_q[i] <= '0;
				x1_q[i]     <= '0;
				x2_q[i]     <= '0;
				y1_q[i]     <= '0;
				y2_q[i]     <= '0;
			end
		end else if (cmd.finish && !pass_q) begin
			lp_mem_q[idx] <= lp_q;
			x1_q[idx]     <= lp_q;
			x2_q[idx]     <= x1_q[idx];
			y1_q[idx]     <= result;
			y2_q[idx]     <= y1_q[idx];
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			sample_q   <= pass_q ? x_q : result;
			chan_out_q <= chan_q;
		end
	end

	assign sample_out  = sample_q;
	assign channel_out = chan_out_q;

endmodule

### hdl/lowpass_highshelf_cascade_core.sv
// lowpass_highshelf_cascade_core: top level of the one-pole lowpass plus
// biquad high shelf. Depends on lhc_pkg, lhc_in_if, lhc_out_if, lhc_regs,
// lhc_ctrl and lhc_dpath.
//
//   port       direction  what moves
//   in_ch      sink       sample_in, channel, enable (one item per handshake)
//   out_ch     source     sample_out, channel_out (one item per input item)
//   cfg_*      write      coefficient register index and data
//
// A filtered item steps from accept through ST_MAC0 to ST_MAC7, which run
// the seven products through one shared 25x24 multiplier and accumulator,
// then ST_FIN, which rounds and writes the result, and back to ST_IDLE,
// which takes the next item. A passed item goes from accept to ST_FIN.
// Reset clears the filter state of every channel and loads the default
// coefficients. A result waits in the output register while out_ch stalls;
// the next finished item then holds in its last cycle until that register is
// handed over, and no new item is taken meanwhile.
`timescale 1ns / 1ps
module lowpass_highshelf_cascade_core
	import lhc_pkg::*;
#(
	parameter int CHANNELS = LHC_CHANNELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lhc_in_if.sink                in_ch,
	lhc_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	coef_t   coef;
	cmd_t    cmd;
	status_t status;

	// coefficient registers
	lhc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	// sequencer
	lhc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// arithmetic and state
	lhc_dpath #(
		.CHANNELS (CHANNELS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_in   (in_ch.sample_in),
		.channel     (in_ch.channel),
		.enable      (in_ch.enable),
		.coef        (coef),
		.cmd         (cmd),
		.status      (status),
		.sample_out  (out_ch.sample_out),
		.channel_out (out_ch.channel_out)
	);

endmodule
